// File: rtl/bcds_pkg.sv
// Package: shared types, codes and constants for the battery status keeper.
`default_nettype none

package bcds_pkg;

   localparam int CAP_W   = 7;
   localparam int MV_W    = 13;
   localparam int TEMP_W  = 12;
   localparam int LIMIT_W = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int LADDER_STEPS = 5;

   // Actions.
   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_EVENT    = 2'd1;
   localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

   // Charger event codes.
   localparam logic [3:0] EV_USB_CHARGE  = 4'd0;
   localparam logic [3:0] EV_AC_CHARGE   = 4'd1;
   localparam logic [3:0] EV_STOP        = 4'd2;
   localparam logic [3:0] EV_START       = 4'd3;
   localparam logic [3:0] EV_NOT_CHARGING = 4'd4;
   localparam logic [3:0] EV_DONE        = 4'd5;
   localparam logic [3:0] EV_OVERVOLTAGE = 4'd6;

   // Charge states.
   localparam logic [1:0] ST_DISCHARGING  = 2'd0;
   localparam logic [1:0] ST_CHARGING     = 2'd1;
   localparam logic [1:0] ST_NOT_CHARGING = 2'd2;
   localparam logic [1:0] ST_FULL         = 2'd3;

   // Health codes.
   localparam logic [1:0] HL_GOOD        = 2'd0;
   localparam logic [1:0] HL_UNKNOWN     = 2'd1;
   localparam logic [1:0] HL_OVERVOLTAGE = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHUTDOWN_MV    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LADDER_1       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LADDER_2       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LADDER_3       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LADDER_4       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LADDER_5       = 3'd6;

   // Register reset values.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 4'd4;
   localparam logic [MV_W-1:0]    SHUTDOWN_RESET = 13'd3400;
   localparam logic [MV_W-1:0]    LADDER_1_RESET = 13'd3500;
   localparam logic [MV_W-1:0]    LADDER_2_RESET = 13'd3600;
   localparam logic [MV_W-1:0]    LADDER_3_RESET = 13'd3700;
   localparam logic [MV_W-1:0]    LADDER_4_RESET = 13'd3800;
   localparam logic [MV_W-1:0]    LADDER_5_RESET = 13'd3900;

   // Capacity estimates for each voltage step, and the full value.
   localparam logic [CAP_W-1:0] CAP_STEP_1 = 7'd5;
   localparam logic [CAP_W-1:0] CAP_STEP_2 = 7'd20;
   localparam logic [CAP_W-1:0] CAP_STEP_3 = 7'd50;
   localparam logic [CAP_W-1:0] CAP_STEP_4 = 7'd75;
   localparam logic [CAP_W-1:0] CAP_STEP_5 = 7'd90;
   localparam logic [CAP_W-1:0] CAP_FULL   = 7'd100;

   typedef struct packed {
      logic [LIMIT_W-1:0]                   debounce_limit;
      logic [MV_W-1:0]                      shutdown_mv;
      logic [LADDER_STEPS-1:0][MV_W-1:0]    ladder_mv;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               action;
      logic [3:0]               event_code;
      logic                     battery_present;
      logic [CAP_W-1:0]         gauge_capacity;
      logic [MV_W-1:0]          voltage_mv;
      logic signed [TEMP_W-1:0] gauge_temperature;
      logic                     charger_present;
   } req_type;

   typedef struct packed {
      logic [CAP_W-1:0]         reported_capacity;
      logic [1:0]               charge_state;
      logic [1:0]               supply_health;
      logic                     usb_power_online;
      logic                     mains_power_online;
      logic                     capacity_changed;
      logic                     battery_fitted;
      logic signed [TEMP_W-1:0] latched_temperature;
      logic                     shutdown_latched;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/battery_capacity_debounce_status.sv
// Battery status keeper top level: input register, status update and result register.
//
// Usage:
//   Each transaction on the req_ channel carries one action (monitor tick,
//   charger event or shutdown check) with fresh gauge readings. Every
//   accepted transaction produces exactly one result transaction on the
//   rsp_ channel, in order, with the capacity and charger status as the
//   action leaves them.
//   An accepted transaction is processed as soon as the result register
//   is free or being read, and its result is registered there with
//   rsp_valid. One transaction per cycle while rsp_ready stays high; the
//   status update is a single pass through compare and select logic
//   between the input register and the result register. The csr_ port
//   writes one configuration register per cycle; the user must write it
//   only while the block is idle, which the block does not enforce;
//   writes to indexes beyond the last register are ignored.
//   Reset clears all status, empties both registers and restores the
//   default thresholds. If the receiver stalls, the result register holds
//   its transaction and the input register takes one more; req_ready then
//   drops until rsp_ready returns.
`default_nettype none

module battery_capacity_debounce_status (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bcds_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bcds_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [bcds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bcds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic              in_valid_ff;
   bcds_pkg::req_type in_data_ff;
   logic              out_valid_ff;
   bcds_pkg::rsp_type out_data_ff;
   logic              step;
   bcds_pkg::cfg_type cfg;
   bcds_pkg::rsp_type result;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   bcds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcds_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A held input transaction is processed as soon as the result slot frees.
   a_no_stuck_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |-> step)
      else $error("pending transaction not processed with free result slot");

   a_zero_on_shutdown: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.shutdown_latched |-> out_data_ff.reported_capacity == '0)
      else $error("nonzero capacity reported after shutdown");

endmodule

`default_nettype wire

// File: rtl/bcds_csr.sv
// Configuration registers: debounce limit, shutdown threshold and voltage ladder.
`default_nettype none

module bcds_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [bcds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bcds_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output bcds_pkg::cfg_type                       cfg
);

   bcds_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit <= bcds_pkg::LIMIT_RESET;
         cfg_ff.shutdown_mv    <= bcds_pkg::SHUTDOWN_RESET;
         cfg_ff.ladder_mv[0]   <= bcds_pkg::LADDER_1_RESET;
         cfg_ff.ladder_mv[1]   <= bcds_pkg::LADDER_2_RESET;
         cfg_ff.ladder_mv[2]   <= bcds_pkg::LADDER_3_RESET;
         cfg_ff.ladder_mv[3]   <= bcds_pkg::LADDER_4_RESET;
         cfg_ff.ladder_mv[4]   <= bcds_pkg::LADDER_5_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bcds_pkg::CSR_DEBOUNCE_LIMIT: begin
               cfg_ff.debounce_limit <= csr_wdata[bcds_pkg::LIMIT_W-1:0];
            end
            bcds_pkg::CSR_SHUTDOWN_MV: cfg_ff.shutdown_mv  <= csr_wdata;
            bcds_pkg::CSR_LADDER_1:    cfg_ff.ladder_mv[0] <= csr_wdata;
            bcds_pkg::CSR_LADDER_2:    cfg_ff.ladder_mv[1] <= csr_wdata;
            bcds_pkg::CSR_LADDER_3:    cfg_ff.ladder_mv[2] <= csr_wdata;
            bcds_pkg::CSR_LADDER_4:    cfg_ff.ladder_mv[3] <= csr_wdata;
            bcds_pkg::CSR_LADDER_5:    cfg_ff.ladder_mv[4] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/bcds_core.sv
// Status state and the combinational update that one transaction applies to it, registered on step.
`default_nettype none

module bcds_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire bcds_pkg::req_type item,
   input  wire bcds_pkg::cfg_type cfg,
   output bcds_pkg::rsp_type result
);

   logic [bcds_pkg::CAP_W-1:0]          held_cap_ff, held_cap_in;
   logic [bcds_pkg::CAP_W-1:0]          last_sample_ff, last_sample_in;
   logic [bcds_pkg::LIMIT_W-1:0]        repeat_ff, repeat_in;
   logic                                started_ff, started_in;
   logic                                fitted_ff, fitted_in;
   logic signed [bcds_pkg::TEMP_W-1:0]  held_temp_ff, held_temp_in;
   logic [1:0]                          status_ff, status_in;
   logic [1:0]                          health_ff, health_in;
   logic                                usb_ff, usb_in;
   logic                                mains_ff, mains_in;
   logic                                shutdown_ff, shutdown_in;

   logic                                present_sel;
   logic [bcds_pkg::CAP_W-1:0]          gauge_sat;
   logic [bcds_pkg::CAP_W-1:0]          ladder_cap;
   logic [bcds_pkg::CAP_W-1:0]          sample;
   logic signed [bcds_pkg::TEMP_W-1:0]  sample_temp;
   logic [bcds_pkg::LIMIT_W-1:0]        repeat_inc;
   logic                                changed;

   // A tick takes presence from the gauge; an event uses the stored bit.
   assign present_sel = (item.action == bcds_pkg::ACT_TICK) ? item.battery_present : fitted_ff;
   assign gauge_sat   = (item.gauge_capacity > bcds_pkg::CAP_FULL) ? bcds_pkg::CAP_FULL
                                                                   : item.gauge_capacity;

   always_comb begin
      if (item.voltage_mv < cfg.ladder_mv[0]) begin
         ladder_cap = bcds_pkg::CAP_STEP_1;
      end else if (item.voltage_mv < cfg.ladder_mv[1]) begin
         ladder_cap = bcds_pkg::CAP_STEP_2;
      end else if (item.voltage_mv < cfg.ladder_mv[2]) begin
         ladder_cap = bcds_pkg::CAP_STEP_3;
      end else if (item.voltage_mv < cfg.ladder_mv[3]) begin
         ladder_cap = bcds_pkg::CAP_STEP_4;
      end else if (item.voltage_mv < cfg.ladder_mv[4]) begin
         ladder_cap = bcds_pkg::CAP_STEP_5;
      end else begin
         ladder_cap = bcds_pkg::CAP_FULL;
      end
   end

   assign sample      = present_sel ? gauge_sat : ladder_cap;
   assign sample_temp = item.battery_present ? item.gauge_temperature : '0;
   assign repeat_inc  = repeat_ff + 1'b1;

   always_comb begin
      held_cap_in    = held_cap_ff;
      last_sample_in = last_sample_ff;
      repeat_in      = repeat_ff;
      started_in     = started_ff;
      fitted_in      = fitted_ff;
      held_temp_in   = held_temp_ff;
      status_in      = status_ff;
      health_in      = health_ff;
      usb_in         = usb_ff;
      mains_in       = mains_ff;
      shutdown_in    = shutdown_ff;
      changed        = 1'b0;

      case (item.action)
         bcds_pkg::ACT_TICK: begin
            fitted_in = item.battery_present;
            if (!started_ff) begin
               started_in     = 1'b1;
               held_cap_in    = sample;
               last_sample_in = sample;
               repeat_in      = '0;
               changed        = 1'b1;
            end else if (shutdown_ff) begin
               changed = 1'b1;
            end else if (sample != last_sample_ff) begin
               last_sample_in = sample;
               repeat_in      = '0;
               if ((usb_ff || mains_ff) && sample == bcds_pkg::CAP_FULL) begin
                  status_in = bcds_pkg::ST_FULL;
               end
            end else begin
               repeat_in = repeat_inc;
               if (repeat_inc >= cfg.debounce_limit) begin
                  if ((usb_ff || mains_ff) && sample == bcds_pkg::CAP_FULL) begin
                     status_in = bcds_pkg::ST_FULL;
                  end
                  held_cap_in  = sample;
                  held_temp_in = sample_temp;
                  repeat_in    = '0;
                  changed      = 1'b1;
               end
            end
         end
         bcds_pkg::ACT_EVENT: begin
            case (item.event_code)
               bcds_pkg::EV_USB_CHARGE: begin
                  usb_in = 1'b1; mains_in = 1'b0;
                  status_in = bcds_pkg::ST_CHARGING; health_in = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_AC_CHARGE: begin
                  mains_in = 1'b1; usb_in = 1'b0;
                  status_in = bcds_pkg::ST_CHARGING; health_in = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_STOP: begin
                  usb_in = 1'b0; mains_in = 1'b0;
                  status_in = bcds_pkg::ST_DISCHARGING; health_in = bcds_pkg::HL_UNKNOWN;
               end
               bcds_pkg::EV_START: begin
                  status_in = bcds_pkg::ST_CHARGING; health_in = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_NOT_CHARGING: begin
                  status_in = bcds_pkg::ST_NOT_CHARGING; health_in = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_DONE: begin
                  status_in = bcds_pkg::ST_FULL; health_in = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_OVERVOLTAGE: begin
                  status_in = bcds_pkg::ST_NOT_CHARGING;
                  health_in = bcds_pkg::HL_OVERVOLTAGE;
               end
               default: ;
            endcase
            // The reload sees the supply flags as this event leaves them.
            held_cap_in = sample;
            if ((usb_in || mains_in) && sample == bcds_pkg::CAP_FULL) begin
               status_in = bcds_pkg::ST_FULL;
            end
         end
         bcds_pkg::ACT_SHUTDOWN: begin
            if (item.voltage_mv < cfg.shutdown_mv && !item.charger_present) begin
               shutdown_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cap_ff    <= '0;
         last_sample_ff <= '0;
         repeat_ff      <= '0;
         started_ff     <= 1'b0;
         fitted_ff      <= 1'b0;
         held_temp_ff   <= '0;
         status_ff      <= bcds_pkg::ST_DISCHARGING;
         health_ff      <= bcds_pkg::HL_GOOD;
         usb_ff         <= 1'b0;
         mains_ff       <= 1'b0;
         shutdown_ff    <= 1'b0;
      end else if (step) begin
         held_cap_ff    <= held_cap_in;
         last_sample_ff <= last_sample_in;
         repeat_ff      <= repeat_in;
         started_ff     <= started_in;
         fitted_ff      <= fitted_in;
         held_temp_ff   <= held_temp_in;
         status_ff      <= status_in;
         health_ff      <= health_in;
         usb_ff         <= usb_in;
         mains_ff       <= mains_in;
         shutdown_ff    <= shutdown_in;
      end
   end

   always_comb begin
      result.reported_capacity   = shutdown_in ? '0 : held_cap_in;
      result.charge_state        = status_in;
      result.supply_health       = health_in;
      result.usb_power_online    = usb_in;
      result.mains_power_online  = mains_in;
      result.capacity_changed    = changed;
      result.battery_fitted      = fitted_in;
      result.latched_temperature = held_temp_in;
      result.shutdown_latched    = shutdown_in;
   end

   // Once latched, shutdown holds until reset.
   a_shutdown_sticky: assert property (@(posedge clock) disable iff (reset)
      shutdown_ff |=> shutdown_ff)
      else $error("shutdown flag cleared without reset");

   a_started_sticky: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag cleared without reset");

   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      held_cap_ff <= bcds_pkg::CAP_FULL && last_sample_ff <= bcds_pkg::CAP_FULL)
      else $error("stored capacity above full scale");

   a_first_tick: assert property (@(posedge clock) disable iff (reset)
      step && !started_ff && item.action == bcds_pkg::ACT_TICK
      |=> started_ff && held_cap_ff == last_sample_ff && repeat_ff == '0)
      else $error("first tick did not load capacity");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the battery status keeper: a directed table, then random phases per setting.
module tb_top;

   localparam logic [1:0] ACT_IDLE        = 2'd3;
   localparam logic [3:0] EV_LOW_WARN     = 4'd7;
   localparam logic [3:0] EV_LOW_SHUTDOWN = 4'd8;
   localparam logic [3:0] EV_OTHER        = 4'd9;
   localparam logic [3:0] EV_CODE_MAX     = 4'd15;
   localparam int ITEMS_PER_PHASE = 445;

   typedef struct {
      bit                on;
      bcds_pkg::rsp_type value;
   } pin_type;

   typedef struct {
      bcds_pkg::req_type item;
      pin_type           pin;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bcds_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bcds_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [bcds_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bcds_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block's registers and status.
   bcds_pkg::cfg_type csr_shadow;
   logic [bcds_pkg::CAP_W-1:0] held_cap = '0;
   logic [bcds_pkg::CAP_W-1:0] last_cap = '0;
   logic [bcds_pkg::LIMIT_W-1:0] repeat_cnt = '0;
   logic started_bit = 1'b0;
   logic fitted_bit = 1'b0;
   logic usb_bit = 1'b0;
   logic mains_bit = 1'b0;
   logic shutdown_bit = 1'b0;
   logic signed [bcds_pkg::TEMP_W-1:0] held_temp = '0;
   logic [1:0] status_now = bcds_pkg::ST_DISCHARGING;
   logic [1:0] health_now = bcds_pkg::HL_GOOD;

   bcds_pkg::rsp_type status_due_q[$];
   pin_type pinned_q[$];
   int mismatch_count = 0;
   bit idle_off = 1'b0;
   int ready_hold = 0;

   // Slowly drifting gauge readings, so that equal samples repeat long enough to debounce.
   logic [bcds_pkg::CAP_W-1:0] drift_gauge = 7'd50;
   logic [bcds_pkg::MV_W-1:0] drift_mv = 13'd3700;
   logic drift_present = 1'b1;

   battery_capacity_debounce_status dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [bcds_pkg::CAP_W-1:0] capacity_sample(
         input logic present,
         input logic [bcds_pkg::CAP_W-1:0] gauge,
         input logic [bcds_pkg::MV_W-1:0] mv);
      if (present) return (gauge > bcds_pkg::CAP_FULL) ? bcds_pkg::CAP_FULL : gauge;
      if (mv < csr_shadow.ladder_mv[0]) return bcds_pkg::CAP_STEP_1;
      if (mv < csr_shadow.ladder_mv[1]) return bcds_pkg::CAP_STEP_2;
      if (mv < csr_shadow.ladder_mv[2]) return bcds_pkg::CAP_STEP_3;
      if (mv < csr_shadow.ladder_mv[3]) return bcds_pkg::CAP_STEP_4;
      if (mv < csr_shadow.ladder_mv[4]) return bcds_pkg::CAP_STEP_5;
      return bcds_pkg::CAP_FULL;
   endfunction

   function automatic void apply_full_rule(input logic [bcds_pkg::CAP_W-1:0] cap);
      if ((usb_bit || mains_bit) && cap == bcds_pkg::CAP_FULL) status_now = bcds_pkg::ST_FULL;
   endfunction

   // Updates the shadow status for one transaction and returns the status it reports.
   function automatic bcds_pkg::rsp_type advance_status(input bcds_pkg::req_type rq);
      logic [bcds_pkg::CAP_W-1:0] sample;
      logic signed [bcds_pkg::TEMP_W-1:0] temp_now;
      logic changed;
      bcds_pkg::rsp_type rs;
      changed = 1'b0;
      case (rq.action)
         bcds_pkg::ACT_TICK: begin
            fitted_bit = rq.battery_present;
            sample = capacity_sample(rq.battery_present, rq.gauge_capacity, rq.voltage_mv);
            temp_now = rq.battery_present ? rq.gauge_temperature : '0;
            if (!started_bit) begin
               started_bit = 1'b1;
               held_cap = sample;
               last_cap = sample;
               repeat_cnt = '0;
               changed = 1'b1;
            end else if (shutdown_bit) begin
               changed = 1'b1;
            end else if (sample != last_cap) begin
               last_cap = sample;
               repeat_cnt = '0;
               apply_full_rule(sample);
            end else begin
               repeat_cnt = repeat_cnt + 1'b1;
               if (repeat_cnt >= csr_shadow.debounce_limit) begin
                  apply_full_rule(sample);
                  held_cap = sample;
                  held_temp = temp_now;
                  repeat_cnt = '0;
                  changed = 1'b1;
               end
            end
         end
         bcds_pkg::ACT_EVENT: begin
            case (rq.event_code)
               bcds_pkg::EV_USB_CHARGE: begin
                  usb_bit = 1'b1;
                  mains_bit = 1'b0;
                  status_now = bcds_pkg::ST_CHARGING;
                  health_now = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_AC_CHARGE: begin
                  mains_bit = 1'b1;
                  usb_bit = 1'b0;
                  status_now = bcds_pkg::ST_CHARGING;
                  health_now = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_STOP: begin
                  usb_bit = 1'b0;
                  mains_bit = 1'b0;
                  status_now = bcds_pkg::ST_DISCHARGING;
                  health_now = bcds_pkg::HL_UNKNOWN;
               end
               bcds_pkg::EV_START: begin
                  status_now = bcds_pkg::ST_CHARGING;
                  health_now = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_NOT_CHARGING: begin
                  status_now = bcds_pkg::ST_NOT_CHARGING;
                  health_now = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_DONE: begin
                  status_now = bcds_pkg::ST_FULL;
                  health_now = bcds_pkg::HL_GOOD;
               end
               bcds_pkg::EV_OVERVOLTAGE: begin
                  status_now = bcds_pkg::ST_NOT_CHARGING;
                  health_now = bcds_pkg::HL_OVERVOLTAGE;
               end
               default: ;
            endcase
            held_cap = capacity_sample(fitted_bit, rq.gauge_capacity, rq.voltage_mv);
            apply_full_rule(held_cap);
         end
         bcds_pkg::ACT_SHUTDOWN: begin
            if (rq.voltage_mv < csr_shadow.shutdown_mv && !rq.charger_present) begin
               shutdown_bit = 1'b1;
            end
         end
         default: ;
      endcase
      rs.reported_capacity = shutdown_bit ? '0 : held_cap;
      rs.charge_state = status_now;
      rs.supply_health = health_now;
      rs.usb_power_online = usb_bit;
      rs.mains_power_online = mains_bit;
      rs.capacity_changed = changed;
      rs.battery_fitted = fitted_bit;
      rs.latched_temperature = held_temp;
      rs.shutdown_latched = shutdown_bit;
      return rs;
   endfunction

   task automatic flag_mismatch(input string field, input int got, input int want);
      $display("%0t: %s got %0d, want %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      bcds_pkg::rsp_type want;
      pin_type pin;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               bcds_pkg::CSR_DEBOUNCE_LIMIT: begin
                  csr_shadow.debounce_limit = csr_wdata[bcds_pkg::LIMIT_W-1:0];
               end
               bcds_pkg::CSR_SHUTDOWN_MV: csr_shadow.shutdown_mv = csr_wdata;
               bcds_pkg::CSR_LADDER_1, bcds_pkg::CSR_LADDER_2, bcds_pkg::CSR_LADDER_3,
               bcds_pkg::CSR_LADDER_4, bcds_pkg::CSR_LADDER_5: begin
                  csr_shadow.ladder_mv[csr_index - bcds_pkg::CSR_LADDER_1] = csr_wdata;
               end
               default: ;
            endcase
         end
         // Results are checked before this edge's transaction is predicted, since a
         // result can never belong to a transaction accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (status_due_q.size() == 0) begin
               flag_mismatch("result with nothing expected, capacity",
                             rsp_data.reported_capacity, -1);
            end else begin
               want = status_due_q.pop_front();
               if (rsp_data.reported_capacity !== want.reported_capacity)
                  flag_mismatch("reported_capacity", rsp_data.reported_capacity,
                                want.reported_capacity);
               if (rsp_data.charge_state !== want.charge_state)
                  flag_mismatch("charge_state", rsp_data.charge_state, want.charge_state);
               if (rsp_data.supply_health !== want.supply_health)
                  flag_mismatch("supply_health", rsp_data.supply_health, want.supply_health);
               if (rsp_data.usb_power_online !== want.usb_power_online)
                  flag_mismatch("usb_power_online", rsp_data.usb_power_online,
                                want.usb_power_online);
               if (rsp_data.mains_power_online !== want.mains_power_online)
                  flag_mismatch("mains_power_online", rsp_data.mains_power_online,
                                want.mains_power_online);
               if (rsp_data.capacity_changed !== want.capacity_changed)
                  flag_mismatch("capacity_changed", rsp_data.capacity_changed,
                                want.capacity_changed);
               if (rsp_data.battery_fitted !== want.battery_fitted)
                  flag_mismatch("battery_fitted", rsp_data.battery_fitted, want.battery_fitted);
               if (rsp_data.latched_temperature !== want.latched_temperature)
                  flag_mismatch("latched_temperature", $signed(rsp_data.latched_temperature),
                                $signed(want.latched_temperature));
               if (rsp_data.shutdown_latched !== want.shutdown_latched)
                  flag_mismatch("shutdown_latched", rsp_data.shutdown_latched,
                                want.shutdown_latched);
            end
         end
         if (req_valid && req_ready) begin
            want = advance_status(req_data);
            if (pinned_q.size() != 0) begin
               pin = pinned_q.pop_front();
               if (pin.on) want = pin.value;
            end
            status_due_q.push_back(want);
         end
      end
   end

   function automatic int stall_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready && !idle_off && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         ready_hold <= stall_len() - 1;
      end else begin
         rsp_ready <= 1'b1;
         ready_hold <= $urandom_range(0, 7);
      end
   end

   task automatic push_item(input bcds_pkg::req_type item, input pin_type pin);
      int gap;
      gap = (!idle_off && $urandom_range(0, 2) == 0) ? stall_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pinned_q.push_back(pin);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lets every outstanding result drain before the registers are touched.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_due_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_setting(input bcds_pkg::cfg_type s);
      csr_we <= 1'b1;
      csr_index <= bcds_pkg::CSR_DEBOUNCE_LIMIT;
      csr_wdata <= bcds_pkg::CSR_DATA_W'(s.debounce_limit);
      @(posedge clock);
      csr_index <= bcds_pkg::CSR_SHUTDOWN_MV;
      csr_wdata <= s.shutdown_mv;
      @(posedge clock);
      for (int k = 0; k < bcds_pkg::LADDER_STEPS; k++) begin
         csr_index <= bcds_pkg::CSR_LADDER_1 + bcds_pkg::CSR_INDEX_W'(k);
         csr_wdata <= s.ladder_mv[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic bcds_pkg::cfg_type setting(
         input logic [bcds_pkg::LIMIT_W-1:0] limit,
         input logic [bcds_pkg::MV_W-1:0] shut,
         input logic [bcds_pkg::MV_W-1:0] l1, input logic [bcds_pkg::MV_W-1:0] l2,
         input logic [bcds_pkg::MV_W-1:0] l3, input logic [bcds_pkg::MV_W-1:0] l4,
         input logic [bcds_pkg::MV_W-1:0] l5);
      bcds_pkg::cfg_type s;
      s.debounce_limit = limit;
      s.shutdown_mv = shut;
      s.ladder_mv = {l5, l4, l3, l2, l1};
      return s;
   endfunction

   function automatic bcds_pkg::req_type req_of(input logic [1:0] act, input logic [3:0] ev,
                                                input logic present, input int gauge,
                                                input int mv, input int temp,
                                                input logic charger);
      bcds_pkg::req_type rq;
      rq.action = act;
      rq.event_code = ev;
      rq.battery_present = present;
      rq.gauge_capacity = bcds_pkg::CAP_W'(gauge);
      rq.voltage_mv = bcds_pkg::MV_W'(mv);
      rq.gauge_temperature = bcds_pkg::TEMP_W'(temp);
      rq.charger_present = charger;
      return rq;
   endfunction

   function automatic bcds_pkg::rsp_type rsp_of(input int cap, input logic [1:0] state,
                                                input logic [1:0] health, input logic usb,
                                                input logic mains, input logic changed,
                                                input logic fitted, input int temp,
                                                input logic shut);
      bcds_pkg::rsp_type rs;
      rs.reported_capacity = bcds_pkg::CAP_W'(cap);
      rs.charge_state = state;
      rs.supply_health = health;
      rs.usb_power_online = usb;
      rs.mains_power_online = mains;
      rs.capacity_changed = changed;
      rs.battery_fitted = fitted;
      rs.latched_temperature = bcds_pkg::TEMP_W'(temp);
      rs.shutdown_latched = shut;
      return rs;
   endfunction

   // A higher churn keeps readings steady longer, which long debounce limits need.
   function automatic bcds_pkg::req_type random_item(input bit allow_latch, input int churn);
      bcds_pkg::req_type rq;
      int pick;
      int mv;
      pick = $urandom_range(0, 99);
      rq.action = (pick < 60) ? bcds_pkg::ACT_TICK :
                  (pick < 78) ? bcds_pkg::ACT_EVENT :
                  (pick < 95) ? bcds_pkg::ACT_SHUTDOWN : ACT_IDLE;
      rq.event_code = ($urandom_range(0, 6) != 0) ? 4'($urandom_range(0, 6)) :
                                                    4'($urandom_range(7, 15));
      if ($urandom_range(0, 3 * churn) == 0) drift_present = ~drift_present;
      if ($urandom_range(0, churn) == 0) begin
         drift_gauge = ($urandom_range(0, 9) != 0) ?
                       bcds_pkg::CAP_W'($urandom_range(0, 100)) :
                       bcds_pkg::CAP_W'($urandom_range(101, 127));
      end
      if ($urandom_range(0, churn) == 0) begin
         pick = $urandom_range(0, bcds_pkg::LADDER_STEPS + 1);
         if (pick < bcds_pkg::LADDER_STEPS) begin
            mv = int'(csr_shadow.ladder_mv[pick]) + int'($urandom_range(0, 4)) - 2;
         end else if (pick == bcds_pkg::LADDER_STEPS) begin
            mv = int'(csr_shadow.shutdown_mv) + int'($urandom_range(0, 4)) - 2;
         end else begin
            mv = $urandom_range(0, 8191);
         end
         drift_mv = (mv < 0) ? '0 : (mv > 8191) ? '1 : bcds_pkg::MV_W'(mv);
      end
      rq.battery_present = drift_present;
      rq.gauge_capacity = drift_gauge;
      rq.voltage_mv = drift_mv;
      rq.gauge_temperature = bcds_pkg::TEMP_W'($urandom);
      // Shutdown latches until reset, so it is held back until late in the run.
      rq.charger_present = (!allow_latch && rq.action == bcds_pkg::ACT_SHUTDOWN) ? 1'b1 :
                                                                  1'($urandom_range(0, 1));
      return rq;
   endfunction

   initial begin : stimulus
      probe_row_type probe_table[$];
      pin_type no_pin;
      pin_type pin;
      bcds_pkg::cfg_type phase_cfg[4];
      int churn[4];
      csr_shadow = setting(bcds_pkg::LIMIT_RESET, bcds_pkg::SHUTDOWN_RESET,
                           bcds_pkg::LADDER_1_RESET, bcds_pkg::LADDER_2_RESET,
                           bcds_pkg::LADDER_3_RESET, bcds_pkg::LADDER_4_RESET,
                           bcds_pkg::LADDER_5_RESET);
      no_pin.on = 1'b0;
      no_pin.value = '0;

      // First tick loads directly; the temperature is not captured on it.
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b1,
                                     60, 4000, 2047, 1'b0),
                              '{1'b1, rsp_of(60, bcds_pkg::ST_DISCHARGING, bcds_pkg::HL_GOOD,
                                             1'b0, 1'b0, 1'b1, 1'b1, 0, 1'b0)}});
      probe_table.push_back('{req_of(ACT_IDLE, EV_CODE_MAX, 1'b0, 127, 8191, -2048, 1'b1),
                              '{1'b1, rsp_of(60, bcds_pkg::ST_DISCHARGING, bcds_pkg::HL_GOOD,
                                             1'b0, 1'b0, 1'b0, 1'b1, 0, 1'b0)}});
      // Gauge above 100 saturates; then four equal ticks take the new value.
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, EV_CODE_MAX, 1'b1, 127, 0, -2048,
                                     1'b1), no_pin});
      for (int i = 0; i < 4; i++) begin
         pin.on = (i == 3);
         pin.value = rsp_of(100, bcds_pkg::ST_DISCHARGING, bcds_pkg::HL_GOOD,
                            1'b0, 1'b0, 1'b1, 1'b1, -400, 1'b0);
         probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_AC_CHARGE, 1'b1,
                                        100, 8191, -400, 1'b0), pin});
      end
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     100, 100, 0, 1'b0),
                              '{1'b1, rsp_of(100, bcds_pkg::ST_FULL, bcds_pkg::HL_GOOD,
                                             1'b1, 1'b0, 1'b0, 1'b1, -400, 1'b0)}});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_AC_CHARGE, 1'b0,
                                     40, 0, 5, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_STOP, 1'b1,
                                     0, 8191, 1, 1'b1), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_START, 1'b0,
                                     100, 3000, 2, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_NOT_CHARGING, 1'b1,
                                     55, 1, 3, 1'b1), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_DONE, 1'b0,
                                     100, 4096, 4, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, bcds_pkg::EV_OVERVOLTAGE, 1'b1,
                                     127, 2, -1, 1'b1), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, EV_LOW_WARN, 1'b0, 1, 3, 0, 1'b0),
                              no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, EV_LOW_SHUTDOWN, 1'b0, 64, 4, 0,
                                     1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_EVENT, EV_OTHER, 1'b1, 99, 5, 0, 1'b1),
                              no_pin});
      // Without a battery, each step of the voltage ladder in turn.
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     0, 0, 100, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     0, 3599, 100, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     0, 3699, 100, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     0, 3799, 100, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     0, 3899, 100, 1'b0), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_TICK, bcds_pkg::EV_USB_CHARGE, 1'b0,
                                     0, 8191, 100, 1'b0), no_pin});
      // Low voltage with a charger, and voltage exactly at the threshold: no latch.
      probe_table.push_back('{req_of(bcds_pkg::ACT_SHUTDOWN, bcds_pkg::EV_STOP, 1'b0,
                                     0, 0, 0, 1'b1), no_pin});
      probe_table.push_back('{req_of(bcds_pkg::ACT_SHUTDOWN, bcds_pkg::EV_STOP, 1'b1,
                                     0, 3400, 0, 1'b0), no_pin});

      phase_cfg[0] = setting(4'd0, 13'd0, 13'd1000, 13'd2500, 13'd3300, 13'd4200, 13'd6000);
      phase_cfg[1] = setting(4'd15, 13'd0, 13'd6000, 13'd0, 13'd6000, 13'd0, 13'd3000);
      phase_cfg[2] = setting(4'($urandom_range(1, 14)), 13'd0,
                             bcds_pkg::MV_W'($urandom_range(0, 6000)),
                             bcds_pkg::MV_W'($urandom_range(0, 6000)),
                             bcds_pkg::MV_W'($urandom_range(0, 6000)),
                             bcds_pkg::MV_W'($urandom_range(0, 6000)),
                             bcds_pkg::MV_W'($urandom_range(0, 6000)));
      phase_cfg[3] = setting(4'd2, 13'd6000, bcds_pkg::LADDER_1_RESET,
                             bcds_pkg::LADDER_2_RESET, bcds_pkg::LADDER_3_RESET,
                             bcds_pkg::LADDER_4_RESET, bcds_pkg::LADDER_5_RESET);
      churn = '{6, 40, 12, 10};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) push_item(probe_table[i].item, probe_table[i].pin);

      for (int p = 0; p < 4; p++) begin
         settle();
         apply_setting(phase_cfg[p]);
         idle_off = (p == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            push_item(random_item(p != 3 || n >= ITEMS_PER_PHASE - 100, churn[p]), no_pin);
         end
      end
      settle();

      if (mismatch_count == 0) begin
         $display("battery_capacity_debounce_status: match");
      end else begin
         $display("battery_capacity_debounce_status: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("battery_capacity_debounce_status: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
rtl/bcds_pkg.sv
rtl/bcds_csr.sv
rtl/bcds_core.sv
rtl/battery_capacity_debounce_status.sv
bench/tb_top.sv
